// ===== rtl/uemr_pkg.sv =====
package uemr_pkg;

    localparam int RING_DEPTH_DEF = 5;

    localparam int TIME_W = 15;
    localparam int DIST_W = 16;
    localparam int PROD_W = 29;
    localparam int DIST_SHIFT = 13;
    localparam logic [PROD_W-1:0] DIST_MUL = PROD_W'(8992);
    localparam logic [DIST_W-1:0] DIST_SAT = 16'h7FFF;
    localparam logic [DIST_W-1:0] DIST_NONE = 16'hFFFF;

    localparam int LIMIT_W = 15;
    localparam int HIGH_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0] OBSTACLE_LIMIT_RST = 15'd3200;
    localparam logic [LIMIT_W-1:0] VALID_LOW_RST = 15'd128;
    localparam logic [HIGH_W-1:0] VALID_HIGH_RST = 16'd28800;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OBSTACLE_LIMIT = 2'd0,
        REG_VALID_LOW      = 2'd1,
        REG_VALID_HIGH     = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CAUSE_NONE       = 2'd0,
        CAUSE_NO_READING = 2'd1,
        CAUSE_STUCK_HIGH = 2'd2,
        CAUSE_STUCK_LOW  = 2'd3
    } cause_t;

    typedef struct packed {
        logic              wr;
        logic              take;
        logic [DIST_W-1:0] distance;
        logic              level;
    } uemr_reading_t;

    typedef struct packed {
        logic [DIST_W-1:0] median;
        logic              up;
        cause_t            why;
    } uemr_status_t;

endpackage

// ===== rtl/uemr_dist.sv =====
module uemr_dist
    import uemr_pkg::*;
(
    input  logic [TIME_W-1:0]  echo_time,
    input  logic [LIMIT_W-1:0] valid_low,
    input  logic [HIGH_W-1:0]  valid_high,
    output logic [DIST_W-1:0]  distance,
    output logic               take
);

    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] raw;

    assign prod     = PROD_W'(echo_time) * DIST_MUL;
    assign raw      = prod[DIST_SHIFT +: DIST_W];
    assign distance = (raw > DIST_SAT) ? DIST_SAT : raw;
    assign take     = (echo_time != '0) && (distance >= DIST_W'(valid_low)) &&
                      (distance <= valid_high);

endmodule

// ===== rtl/uemr_channel.sv =====
module uemr_channel
    import uemr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  uemr_reading_t rd,
    output uemr_status_t  status
);

    localparam int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int MID = RING_DEPTH / 2;

    logic [DIST_W-1:0] ring_reg [RING_DEPTH];
    logic [SW-1:0]     slot_reg;
    logic              filled_reg;
    logic              up_reg;
    cause_t            why_reg;

    logic [SW-1:0]     rank [RING_DEPTH];
    logic [DIST_W-1:0] median;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_reg[i] <= DIST_NONE;
            end
            slot_reg   <= '0;
            filled_reg <= 1'b0;
            up_reg     <= 1'b0;
            why_reg    <= CAUSE_NO_READING;
        end else if (rd.wr) begin
            if (rd.take) begin
                ring_reg[slot_reg] <= rd.distance;
                slot_reg   <= (slot_reg == SW'(RING_DEPTH - 1)) ? '0 : slot_reg + SW'(1);
                filled_reg <= 1'b1;
                up_reg     <= 1'b1;
                why_reg    <= CAUSE_NONE;
            end else begin
                up_reg     <= 1'b0;
                why_reg    <= rd.level ? CAUSE_STUCK_HIGH : CAUSE_STUCK_LOW;
            end
        end
    end

    // rank each entry, ties broken by position
    always_comb begin
        for (int i = 0; i < RING_DEPTH; i++) begin
            rank[i] = '0;
            for (int j = 0; j < RING_DEPTH; j++) begin
                if (j != i) begin
                    if (($signed(ring_reg[j]) < $signed(ring_reg[i])) ||
                        ((ring_reg[j] == ring_reg[i]) && (j < i))) begin
                        rank[i] = rank[i] + SW'(1);
                    end
                end
            end
        end
        median = DIST_NONE;
        for (int i = 0; i < RING_DEPTH; i++) begin
            if (rank[i] == SW'(MID)) begin
                median = ring_reg[i];
            end
        end
    end

    assign status.median = filled_reg ? median : DIST_NONE;
    assign status.up     = up_reg;
    assign status.why    = why_reg;

endmodule

// ===== rtl/ultrasonic_echo_median_ranger_top.sv =====
// Ultrasonic echo ranger: each request carries one echo pulse width and the echo
// level; requests alternate front, rear, front... starting with front after reset.
// The block takes one request per clock cycle while the output side is not stalled and
// delivers one result per request through an input register, a distance stage that
// converts the width, checks the limits and writes the sensor ring, and a result
// register loaded from the median-of-RING_DEPTH rank network of both rings. A stalled
// result holds in the output register while the earlier stages keep filling. Limit
// registers must be written only while the block is idle; the block does not check it.
module ultrasonic_echo_median_ranger_top
    import uemr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // echo_time[14:0], echo_level[15]
    input  logic [15:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // front_median[15:0], rear_median[31:16], nearest[47:32], farthest[63:48],
    // front_ok[64], rear_ok[65], front_blocked[66], rear_blocked[67],
    // any_blocked[68], front_cause[70:69], rear_cause[72:71], zero pad [79:73]
    output logic [79:0]           m_tdata,
    // was_front[0]
    output logic                  m_tuser
);

    logic [LIMIT_W-1:0] obstacle_limit_reg;
    logic [LIMIT_W-1:0] valid_low_reg;
    logic [HIGH_W-1:0]  valid_high_reg;

    logic               s1_valid_reg;
    logic [TIME_W-1:0]  s1_time_reg;
    logic               s1_level_reg;
    logic               s2_valid_reg;
    logic               s2_front_reg;
    logic               next_is_front_reg;

    logic               out_valid_reg;
    logic [DIST_W-1:0]  front_median_reg;
    logic [DIST_W-1:0]  rear_median_reg;
    logic [DIST_W-1:0]  nearest_reg;
    logic [DIST_W-1:0]  farthest_reg;
    logic               front_ok_reg;
    logic               rear_ok_reg;
    logic               front_blocked_reg;
    logic               rear_blocked_reg;
    cause_t             front_cause_reg;
    cause_t             rear_cause_reg;
    logic               was_front_reg;

    logic               out_move;
    logic               s2_move;
    logic               s1_move;
    logic               s1_fire;
    logic               s2_fire;

    logic [DIST_W-1:0]  distance;
    logic               take;
    uemr_reading_t      front_rd;
    uemr_reading_t      rear_rd;
    uemr_status_t       front_st;
    uemr_status_t       rear_st;

    logic [DIST_W-1:0]  nearest_next;
    logic [DIST_W-1:0]  farthest_next;
    logic               front_blocked_next;
    logic               rear_blocked_next;

    assign out_move = m_tready || !out_valid_reg;
    assign s2_move  = out_move || !s2_valid_reg;
    assign s1_move  = s2_move || !s1_valid_reg;
    assign s_tready = s1_move;
    assign s1_fire  = s1_valid_reg && s2_move;
    assign s2_fire  = s2_valid_reg && out_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obstacle_limit_reg <= OBSTACLE_LIMIT_RST;
            valid_low_reg      <= VALID_LOW_RST;
            valid_high_reg     <= VALID_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OBSTACLE_LIMIT: obstacle_limit_reg <= cfg_wr_data[LIMIT_W-1:0];
                REG_VALID_LOW:      valid_low_reg      <= cfg_wr_data[LIMIT_W-1:0];
                REG_VALID_HIGH:     valid_high_reg     <= cfg_wr_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            next_is_front_reg <= 1'b1;
        end else begin
            if (s1_move) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_move) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_move) begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_fire) begin
                next_is_front_reg <= !next_is_front_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && s_tvalid) begin
            s1_time_reg  <= s_tdata[TIME_W-1:0];
            s1_level_reg <= s_tdata[15];
        end
        if (s1_fire) begin
            s2_front_reg <= next_is_front_reg;
        end
        if (s2_fire) begin
            front_median_reg  <= front_st.median;
            rear_median_reg   <= rear_st.median;
            nearest_reg       <= nearest_next;
            farthest_reg      <= farthest_next;
            front_ok_reg      <= front_st.up;
            rear_ok_reg       <= rear_st.up;
            front_blocked_reg <= front_blocked_next;
            rear_blocked_reg  <= rear_blocked_next;
            front_cause_reg   <= front_st.why;
            rear_cause_reg    <= rear_st.why;
            was_front_reg     <= s2_front_reg;
        end
    end

    uemr_dist u_dist (
        .echo_time  (s1_time_reg),
        .valid_low  (valid_low_reg),
        .valid_high (valid_high_reg),
        .distance   (distance),
        .take       (take)
    );

    always_comb begin
        front_rd.wr       = s1_fire && next_is_front_reg;
        front_rd.take     = take;
        front_rd.distance = distance;
        front_rd.level    = s1_level_reg;
        rear_rd.wr        = s1_fire && !next_is_front_reg;
        rear_rd.take      = take;
        rear_rd.distance  = distance;
        rear_rd.level     = s1_level_reg;
    end

    uemr_channel #(.RING_DEPTH(RING_DEPTH)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (front_rd),
        .status  (front_st)
    );

    uemr_channel #(.RING_DEPTH(RING_DEPTH)) u_rear (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rear_rd),
        .status  (rear_st)
    );

    always_comb begin
        if ($signed(front_st.median) < 0) begin
            nearest_next  = rear_st.median;
            farthest_next = rear_st.median;
        end else if ($signed(rear_st.median) < 0) begin
            nearest_next  = front_st.median;
            farthest_next = front_st.median;
        end else if ($signed(front_st.median) < $signed(rear_st.median)) begin
            nearest_next  = front_st.median;
            farthest_next = rear_st.median;
        end else begin
            nearest_next  = rear_st.median;
            farthest_next = front_st.median;
        end
        front_blocked_next = ($signed(front_st.median) > 0) &&
                             (front_st.median <= DIST_W'(obstacle_limit_reg));
        rear_blocked_next  = ($signed(rear_st.median) > 0) &&
                             (rear_st.median <= DIST_W'(obstacle_limit_reg));
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = was_front_reg;
    assign m_tdata  = {7'b0, rear_cause_reg, front_cause_reg,
                       front_blocked_reg || rear_blocked_reg,
                       rear_blocked_reg, front_blocked_reg, rear_ok_reg, front_ok_reg,
                       farthest_reg, nearest_reg, rear_median_reg, front_median_reg};

    a_side_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire |=> (s2_front_reg != next_is_front_reg))
        else $error("sensor tag does not follow alternation");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(farthest_reg) >= $signed(nearest_reg)))
        else $error("farthest below nearest");

    a_block_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (front_blocked_reg || rear_blocked_reg)) |->
        (($signed(front_median_reg) > 0) || ($signed(rear_median_reg) > 0)))
        else $error("blocked without a positive median");

    a_ok_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && front_ok_reg) |-> (front_cause_reg == CAUSE_NONE))
        else $error("front online with a cause set");

endmodule

// ===== bench/tb_ultrasonic_echo_median_ranger_top.sv =====
module tb_ultrasonic_echo_median_ranger_top;
    import uemr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned US_TO_DIST = 8992;
    localparam int DIST_FRAC = 13;
    localparam int unsigned DIST_CEIL = 32767;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int FRONT = 0;
    localparam int REAR = 1;

    typedef struct {
        logic signed [15:0] front_median;
        logic signed [15:0] rear_median;
        logic signed [15:0] nearest;
        logic signed [15:0] farthest;
        logic               front_ok;
        logic               rear_ok;
        logic               front_blocked;
        logic               rear_blocked;
        logic               any_blocked;
        cause_t             front_cause;
        cause_t             rear_cause;
        logic               was_front;
    } range_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [79:0]           m_tdata;
    logic                  m_tuser;

    // predictor state
    int unsigned        obstacle_limit;
    int unsigned        valid_low;
    int unsigned        valid_high;
    logic signed [15:0] echo_ring [2][RING_DEPTH_DEF];
    int                 ring_slot [2];
    logic               ring_filled [2];
    logic               sensor_up [2];
    cause_t             sensor_cause [2];
    logic               next_front;

    range_report_t pending_reports [$];
    range_report_t want;
    int            err_count = 0;
    int            quiet_cycles = 0;
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    bit            hold_request = 1'b0;
    int            hold_left = 0;

    ultrasonic_echo_median_ranger_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void reset_ranger();
        obstacle_limit = 3200;
        valid_low = 128;
        valid_high = 28800;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < RING_DEPTH_DEF; i++) echo_ring[s][i] = -16'sd1;
            ring_slot[s] = 0;
            ring_filled[s] = 1'b0;
            sensor_up[s] = 1'b0;
            sensor_cause[s] = CAUSE_NO_READING;
        end
        next_front = 1'b1;
    endfunction

    function automatic logic signed [15:0] ring_median(int s);
        logic signed [15:0] v [RING_DEPTH_DEF];
        logic signed [15:0] x;
        int j;
        if (!ring_filled[s]) return -16'sd1;
        for (int i = 0; i < RING_DEPTH_DEF; i++) begin
            x = echo_ring[s][i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return v[RING_DEPTH_DEF/2];
    endfunction

    function automatic logic is_blocked(logic signed [15:0] m);
        return m > 0 && int'(m) <= int'(obstacle_limit);
    endfunction

    function automatic range_report_t predict_report(logic [14:0] echo_us, logic level);
        range_report_t r;
        int unsigned d;
        int s;
        s = next_front ? FRONT : REAR;
        d = (int'(echo_us) * US_TO_DIST) >> DIST_FRAC;
        if (d > DIST_CEIL) d = DIST_CEIL;
        if (echo_us != 0 && d >= valid_low && d <= valid_high) begin
            echo_ring[s][ring_slot[s]] = 16'(d);
            ring_slot[s] = (ring_slot[s] + 1) % RING_DEPTH_DEF;
            ring_filled[s] = 1'b1;
            sensor_up[s] = 1'b1;
            sensor_cause[s] = CAUSE_NONE;
        end else begin
            sensor_up[s] = 1'b0;
            sensor_cause[s] = level ? CAUSE_STUCK_HIGH : CAUSE_STUCK_LOW;
        end
        r.was_front = next_front;
        next_front = !next_front;
        r.front_median = ring_median(FRONT);
        r.rear_median = ring_median(REAR);
        if (r.front_median < 0) begin
            r.nearest = r.rear_median;
            r.farthest = r.rear_median;
        end else if (r.rear_median < 0) begin
            r.nearest = r.front_median;
            r.farthest = r.front_median;
        end else begin
            r.nearest = (r.front_median < r.rear_median) ? r.front_median : r.rear_median;
            r.farthest = (r.front_median < r.rear_median) ? r.rear_median : r.front_median;
        end
        r.front_ok = sensor_up[FRONT];
        r.rear_ok = sensor_up[REAR];
        r.front_blocked = is_blocked(r.front_median);
        r.rear_blocked = is_blocked(r.rear_median);
        r.any_blocked = r.front_blocked | r.rear_blocked;
        r.front_cause = sensor_cause[FRONT];
        r.rear_cause = sensor_cause[REAR];
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            err_count++;
            $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic logic [14:0] pick_echo_time();
        case ($urandom_range(9))
            0: return 15'd0;
            1: return 15'($urandom_range(32767));
            2: return 15'($urandom_range(3500));
            3: return 15'($urandom_range(140, 100));
            4: return 15'($urandom_range(26300, 26150));
            default: return 15'($urandom_range(26500, 150));
        endcase
    endfunction

    task automatic send_echo(input logic [14:0] echo_us, input logic level);
        while (tx_idle && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {level, echo_us};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_reports.push_back(predict_report(echo_us, level));
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_echo(pick_echo_time(), 1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_limits(int unsigned obstacle, int unsigned low, int unsigned high);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OBSTACLE_LIMIT;
        cfg_wr_data <= 16'(obstacle);
        @(posedge aclk);
        obstacle_limit = obstacle & 32'h7FFF;
        cfg_index <= REG_VALID_LOW;
        cfg_wr_data <= 16'(low);
        @(posedge aclk);
        valid_low = low & 32'h7FFF;
        cfg_index <= REG_VALID_HIGH;
        cfg_wr_data <= 16'(high);
        @(posedge aclk);
        valid_high = high & 32'hFFFF;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_edges();
        send_echo(15'd0, 1'b0);
        send_echo(15'd0, 1'b1);
        send_echo(15'd116, 1'b1);
        send_echo(15'd116, 1'b0);
        send_echo(15'd117, 1'b0);
        send_echo(15'd117, 1'b1);
        send_echo(15'd26238, 1'b0);
        send_echo(15'd26239, 1'b1);
        send_echo(15'd32767, 1'b1);
        send_echo(15'd32767, 1'b0);
        send_echo(15'd2915, 1'b0);
        send_echo(15'd2916, 1'b0);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        program_limits(32'h7FFF, 0, 32'hFFFF);
        send_echo(15'd1, 1'b0);
        send_echo(15'd32767, 1'b1);
        send_echo(15'd0, 1'b1);
        send_echo(15'd30000, 1'b0);
        wait_drained();
        program_limits(0, 32'h7FFF, 0);
        send_echo(15'd500, 1'b1);
        send_echo(15'd500, 1'b0);
        send_echo(15'd32767, 1'b0);
        wait_drained();
        program_limits(28800, 28800, 32929);
        send_echo(15'd26238, 1'b0);
        send_echo(15'd26238, 1'b1);
        send_echo(15'd30000, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_default();
        program_limits(3200, 128, 28800);
        send_random(300);
        wait_drained();
    endtask

    task automatic test_random_steady();
        program_limits(32'h7FFF, 0, 32'hFFFF);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(200);
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        program_limits($urandom_range(28800), $urandom_range(3000), $urandom_range(32929, 20000));
        tx_idle = 1'b0;
        hold_request = 1'b1;
        send_random(40);
        tx_idle = 1'b1;
        send_random(110);
        wait_drained();
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 3; p++) begin
            if (p == 2) program_limits($urandom_range(28800), 20000, 10000);
            else program_limits($urandom_range(28800), $urandom_range(3000),
                                $urandom_range(32929, 15000));
            send_random(100);
            wait_drained();
        end
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !rx_idle || $urandom_range(99) >= 19;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                err_count++;
                $display("%0t unexpected result expected none actual %h", $time, m_tdata);
            end else begin
                want = pending_reports.pop_front();
                check_field("front_median", want.front_median, $signed(m_tdata[15:0]));
                check_field("rear_median", want.rear_median, $signed(m_tdata[31:16]));
                check_field("nearest", want.nearest, $signed(m_tdata[47:32]));
                check_field("farthest", want.farthest, $signed(m_tdata[63:48]));
                check_field("front_ok", want.front_ok, m_tdata[64]);
                check_field("rear_ok", want.rear_ok, m_tdata[65]);
                check_field("front_blocked", want.front_blocked, m_tdata[66]);
                check_field("rear_blocked", want.rear_blocked, m_tdata[67]);
                check_field("any_blocked", want.any_blocked, m_tdata[68]);
                check_field("front_cause", want.front_cause, m_tdata[70:69]);
                check_field("rear_cause", want.rear_cause, m_tdata[72:71]);
                check_field("pad", 0, m_tdata[79:73]);
                check_field("was_front", want.was_front, m_tuser);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_ranger();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_edges();
        test_limit_extremes();
        test_random_default();
        test_random_steady();
        test_backpressure();
        test_random_configs();
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
